FILE: design/mst_pkg.sv
// Shared types and codes for the multiplexed software timer unit.
// No dependencies; imported by multiplexed_software_timers_unit.
package mst_pkg;

  // field widths fixed by the interface
  localparam int OP_W   = 2;
  localparam int DUR_W  = 32;
  localparam int TAG_W  = 8;
  localparam int IDX_W  = 4;
  localparam int KIND_W = 3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [KIND_W-1:0] kind_t;

  // operation codes
  localparam op_t OP_DECLARE = 2'd0;
  localparam op_t OP_CANCEL  = 2'd1;
  localparam op_t OP_TICK    = 2'd2;

  // result kinds
  localparam kind_t KIND_DECLARED  = 3'd0;
  localparam kind_t KIND_FULL      = 3'd1;
  localparam kind_t KIND_CANCELLED = 3'd2;
  localparam kind_t KIND_UNUSED    = 3'd3;
  localparam kind_t KIND_EXPIRED   = 3'd4;

  // one result item without its last flag
  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   slot;
    logic [TAG_W-1:0]   tag;
  } result_t;

endpackage

FILE: design/multiplexed_software_timers_unit.sv
// Multiplexed one-shot software timers on one shared countdown.
// Depends on mst_pkg (codes and result type).
//
// One item is worked at a time. A declare or a cancel that needs no rescan
// passes through three steps from transfer to the final result (accept,
// decide, hand over). An expiry, a cancel of the nearest timer or a declare
// shorter than the nearest timer rescans the slot memory, one slot per
// cycle over its single read port. While the result side stalls, a rescan
// holds at the next expired slot. A tick that expires nothing gives no result.
// Results of one item are buffered one deep so that the final one can carry
// the last flag; the next item is taken while the last result still waits.
module multiplexed_software_timers_unit #(
  parameter int SLOT_COUNT = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mst_pkg::OP_W-1:0]     in_operation,
  input  logic [mst_pkg::DUR_W-1:0]    in_duration,
  input  logic [mst_pkg::TAG_W-1:0]    in_event_tag,
  input  logic [mst_pkg::IDX_W-1:0]    in_slot_index,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mst_pkg::KIND_W-1:0]   out_kind,
  output logic [mst_pkg::IDX_W-1:0]    out_slot,
  output logic [mst_pkg::TAG_W-1:0]    out_tag,
  output logic                         out_last
);
  import mst_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WIDE_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {S_IDLE, S_OP, S_WALK, S_FINISH} state_t;

  state_t                  state_r;

  // latched input item
  op_t                     op_r;
  logic [DUR_W-1:0]        dur_r;
  logic [TAG_W-1:0]        tag_in_r;
  logic [IDX_W-1:0]        idx_r;

  // timer state
  logic [SLOT_COUNT-1:0]   busy_r;
  logic [SLOT_W-1:0]       nearest_slot_r;
  logic                    nearest_valid_r;
  logic [TIME_BITS-1:0]    nearest_rem_r;
  logic [TIME_BITS-1:0]    elapsed_r;

  // slot memories and their registered read data
  logic [TIME_BITS-1:0]    rem_mem_r [SLOT_COUNT];
  logic [TAG_W-1:0]        tag_mem_r [SLOT_COUNT];
  logic [TIME_BITS-1:0]    rd_rem_r;
  logic [TAG_W-1:0]        rd_tag_r;

  // rescan bookkeeping
  logic [SLOT_W-1:0]       walk_r;
  logic                    found_r;
  logic [SLOT_W-1:0]       best_r;
  logic [TIME_BITS-1:0]    best_val_r;
  logic                    adv_r;
  logic                    decl_ok_r;
  logic                    decl_short_r;
  logic [SLOT_W-1:0]       decl_slot_r;

  // one-deep result hold and output register
  logic                    hold_v_r;
  result_t                 hold_r;
  logic                    out_valid_r;
  result_t                 out_res_r;
  logic                    out_last_r;
  logic                    out_load;

  // memory port controls
  logic [SLOT_W-1:0]       rd_addr;
  logic                    rem_we;
  logic [SLOT_W-1:0]       rem_waddr;
  logic [TIME_BITS-1:0]    rem_wdata;
  logic                    tag_we;

  // decode of the latched item
  logic                    out_free;
  logic                    free_found;
  logic [SLOT_W-1:0]       free_idx;
  logic [TIME_BITS-1:0]    dur_sat;
  logic [TIME_BITS-1:0]    left;
  logic [TIME_BITS:0]      sum_wide;
  logic [TIME_BITS-1:0]    sum_sat;
  logic [TIME_BITS-1:0]    tick_el;
  logic                    idx_in_range;
  logic [SLOT_W-1:0]       idx_ext;
  logic                    d_ok;
  logic                    d_fresh;
  logic                    d_short;
  logic                    d_long;
  logic                    c_hit;
  logic                    c_near;
  logic                    t_adv;

  // rescan step
  logic                    w_busy;
  logic                    w_live;
  logic [TIME_BITS-1:0]    w_new;
  logic                    w_better;
  logic                    w_expire;
  logic                    w_hold_stall;
  logic                    w_last;
  logic                    finish_go;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_kind  = out_res_r.kind;
  assign out_slot  = out_res_r.slot;
  assign out_tag   = out_res_r.tag;
  assign out_last  = out_last_r;

  // output register can take a transfer this cycle
  assign out_free = !out_valid_r || !out_stall;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // time arithmetic for declare and tick
  always_comb begin
    dur_sat  = (WIDE_W'(dur_r) > WIDE_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(dur_r);
    left     = (nearest_rem_r > elapsed_r) ? (nearest_rem_r - elapsed_r) : '0;
    sum_wide = {1'b0, dur_sat} + {1'b0, elapsed_r};
    sum_sat  = sum_wide[TIME_BITS] ? TIME_MAX : sum_wide[TIME_BITS-1:0];
    tick_el  = (elapsed_r == TIME_MAX) ? elapsed_r : (elapsed_r + TIME_BITS'(1));
  end

  // operation decode
  assign idx_in_range = (32'(idx_r) < SLOT_COUNT);
  assign idx_ext      = SLOT_W'(idx_r);
  assign d_ok    = (op_r == OP_DECLARE) && free_found;
  assign d_fresh = d_ok && !nearest_valid_r;
  assign d_short = d_ok && nearest_valid_r && (dur_sat < left);
  assign d_long  = d_ok && nearest_valid_r && !(dur_sat < left);
  assign c_hit   = (op_r == OP_CANCEL) && idx_in_range && busy_r[idx_ext];
  assign c_near  = c_hit && nearest_valid_r && (nearest_slot_r == idx_ext);
  assign t_adv   = (op_r == OP_TICK) && nearest_valid_r && (tick_el >= nearest_rem_r);

  // one rescan step on the slot whose data is in the read register
  always_comb begin
    w_busy       = busy_r[walk_r];
    w_live       = (elapsed_r < rd_rem_r);
    w_new        = rd_rem_r - elapsed_r;
    w_better     = !found_r || (w_new < best_val_r);
    w_expire     = w_busy && !w_live;
    w_hold_stall = w_expire && hold_v_r && !out_free;
    w_last       = (walk_r == LAST_SLOT);
  end

  assign finish_go = !hold_v_r || out_free;

  // held result moves into the output register this cycle
  assign out_load = hold_v_r &&
                    (((state_r == S_WALK) && w_expire && !w_hold_stall) ||
                     ((state_r == S_FINISH) && finish_go));

  // read address: first slot when a rescan starts, then the next one
  always_comb begin
    rd_addr = walk_r;
    if (state_r == S_OP) begin
      rd_addr = '0;
    end else if (state_r == S_WALK && !w_hold_stall && !w_last) begin
      rd_addr = walk_r + SLOT_W'(1);
    end
  end

  // remaining-time write port
  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = free_idx;
    rem_wdata = dur_sat;
    tag_we    = 1'b0;
    unique case (state_r)
      S_OP: begin
        tag_we = d_ok;
        if (d_fresh) begin
          rem_we = 1'b1;
        end else if (d_long) begin
          rem_we    = 1'b1;
          rem_wdata = sum_sat;
        end
      end
      S_WALK: begin
        rem_we    = w_busy && w_live;
        rem_waddr = walk_r;
        rem_wdata = w_new;
      end
      S_FINISH: begin
        rem_we    = finish_go && decl_short_r;
        rem_waddr = decl_slot_r;
      end
      default: begin
        rem_we = 1'b0;
      end
    endcase
  end

  // slot memories, registered read
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem_r[rem_waddr] <= rem_wdata;
    end
    if (tag_we) begin
      tag_mem_r[free_idx] <= tag_in_r;
    end
    rd_rem_r <= rem_mem_r[rd_addr];
    rd_tag_r <= tag_mem_r[rd_addr];
  end

  // sequencer, timer state and result path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      busy_r          <= '0;
      nearest_slot_r  <= '0;
      nearest_valid_r <= 1'b0;
      nearest_rem_r   <= '0;
      elapsed_r       <= '0;
      hold_v_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      adv_r           <= 1'b0;
      decl_ok_r       <= 1'b0;
      decl_short_r    <= 1'b0;
      found_r         <= 1'b0;
      walk_r          <= '0;
    end else begin
      // output register drains on a transfer unless refilled
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_operation;
            dur_r    <= in_duration;
            tag_in_r <= in_event_tag;
            idx_r    <= in_slot_index;
            state_r  <= S_OP;
          end
        end

        S_OP: begin
          adv_r        <= d_short || c_near || t_adv;
          decl_ok_r    <= d_ok;
          decl_short_r <= d_short;
          decl_slot_r  <= free_idx;
          found_r      <= 1'b0;
          best_r       <= '0;
          best_val_r   <= '0;
          walk_r       <= '0;
          unique case (op_r)
            OP_DECLARE: begin
              hold_v_r <= 1'b1;
              if (!free_found) begin
                hold_r  <= '{kind: KIND_FULL, slot: '0, tag: '0};
                state_r <= S_FINISH;
              end else begin
                hold_r <= '{kind: KIND_DECLARED, slot: IDX_W'(free_idx), tag: '0};
                if (d_fresh) begin
                  elapsed_r       <= '0;
                  nearest_slot_r  <= free_idx;
                  nearest_valid_r <= 1'b1;
                  nearest_rem_r   <= dur_sat;
                end
                if (d_short) begin
                  state_r <= S_WALK;
                end else begin
                  state_r <= S_FINISH;
                end
              end
            end
            OP_CANCEL: begin
              hold_v_r <= 1'b1;
              if (!c_hit) begin
                hold_r  <= '{kind: KIND_UNUSED, slot: idx_r, tag: '0};
                state_r <= S_FINISH;
              end else begin
                busy_r[idx_ext] <= 1'b0;
                hold_r <= '{kind: KIND_CANCELLED, slot: idx_r, tag: '0};
                if (c_near) begin
                  state_r <= S_WALK;
                end else begin
                  state_r <= S_FINISH;
                end
              end
            end
            OP_TICK: begin
              if (nearest_valid_r) begin
                elapsed_r <= tick_el;
              end
              if (t_adv) begin
                state_r <= S_WALK;
              end else begin
                state_r <= S_IDLE;
              end
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end

        S_WALK: begin
          if (!w_hold_stall) begin
            if (w_busy) begin
              if (w_live) begin
                // track the new nearest timer, lowest slot wins a tie
                if (w_better) begin
                  found_r    <= 1'b1;
                  best_r     <= walk_r;
                  best_val_r <= w_new;
                end
              end else begin
                // expired: free the slot, pass the held result on
                busy_r[walk_r] <= 1'b0;
                if (hold_v_r) begin
                  out_valid_r <= 1'b1;
                  out_res_r   <= hold_r;
                  out_last_r  <= 1'b0;
                end
                hold_v_r <= 1'b1;
                hold_r   <= '{kind: KIND_EXPIRED, slot: IDX_W'(walk_r), tag: rd_tag_r};
              end
            end
            if (w_last) begin
              state_r <= S_FINISH;
            end else begin
              walk_r <= walk_r + SLOT_W'(1);
            end
          end
        end

        S_FINISH: begin
          if (finish_go) begin
            if (hold_v_r) begin
              out_valid_r <= 1'b1;
              out_res_r   <= hold_r;
              out_last_r  <= 1'b1;
            end
            hold_v_r <= 1'b0;
            if (decl_ok_r) begin
              busy_r[decl_slot_r] <= 1'b1;
            end
            // a shorter declare becomes the nearest timer, otherwise the
            // countdown restarts on the rescan's nearest slot
            if (decl_short_r) begin
              nearest_slot_r  <= decl_slot_r;
              nearest_valid_r <= 1'b1;
              nearest_rem_r   <= dur_sat;
              elapsed_r       <= '0;
            end else if (adv_r) begin
              nearest_valid_r <= found_r;
              nearest_slot_r  <= found_r ? best_r : '0;
              nearest_rem_r   <= best_val_r;
              elapsed_r       <= '0;
            end
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // between items the nearest timer is a running slot
  a_nearest_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && nearest_valid_r) |-> busy_r[nearest_slot_r])
    else $error("nearest slot is not busy");

  // the countdown never runs past the nearest timer between items
  a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && nearest_valid_r) |-> (elapsed_r <= nearest_rem_r))
    else $error("elapsed time beyond nearest timer");

  // no countdown runs while no timer is running
  a_elapsed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !nearest_valid_r) |-> (elapsed_r == '0))
    else $error("elapsed time without a running timer");

  // the result hold is empty whenever a new item may be taken
  a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("result left in hold after item end");

endmodule
